// ===== hw/rtl/sswt_pkg.sv =====
// sswt_pkg: shared types and constants for the sensor switch output timer
// holds the configuration bundle, register indexes, mode codes and reset values
// no dependencies
`timescale 1ns / 1ps

package sswt_pkg;

  // field widths
  localparam int ADC_W   = 12;
  localparam int THR_W   = 12;
  localparam int HYST_W  = 8;
  localparam int MODE_W  = 2;
  localparam int DVAL_W  = 14;
  localparam int BASE_W  = 8;
  localparam int LIMIT_W = DVAL_W + BASE_W;
  localparam int CFG_W   = 14;
  localparam int IDX_W   = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_THRESHOLD   = 3'd0;
  localparam logic [IDX_W-1:0] REG_HYSTERESIS  = 3'd1;
  localparam logic [IDX_W-1:0] REG_POLARITY    = 3'd2;
  localparam logic [IDX_W-1:0] REG_DELAY_MODE  = 3'd3;
  localparam logic [IDX_W-1:0] REG_DELAY_VALUE = 3'd4;
  localparam logic [IDX_W-1:0] REG_BASE_TIME   = 3'd5;

  // delay modes
  localparam logic [MODE_W-1:0] MODE_DIRECT    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OFF_DELAY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ON_DELAY  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ONE_SHOT  = 2'd3;

  // reset values
  localparam logic [THR_W-1:0]  RST_THRESHOLD   = 12'd1000;
  localparam logic [HYST_W-1:0] RST_HYSTERESIS  = 8'd50;
  localparam logic              RST_POLARITY    = 1'b1;
  localparam logic [MODE_W-1:0] RST_DELAY_MODE  = MODE_DIRECT;
  localparam logic [DVAL_W-1:0] RST_DELAY_VALUE = 14'd10;
  localparam logic [BASE_W-1:0] RST_BASE_TIME   = 8'd23;

  // settings seen by the core
  typedef struct packed {
    logic [THR_W-1:0]   threshold;
    logic [HYST_W-1:0]  hysteresis;
    logic               polarity;
    logic [MODE_W-1:0]  delay_mode;
    logic [LIMIT_W-1:0] limit;
  } sswt_cfg_t;

  // one result beat
  typedef struct packed {
    logic compare_bit;
    logic detect;
    logic out_pin;
  } sswt_res_t;

endpackage

// ===== hw/rtl/sensor_switch_output_timer_unit.sv =====
// sensor_switch_output_timer_unit: top level of the sensor switch output timer
// depends on sswt_pkg, sswt_cfg and sswt_core
`timescale 1ns / 1ps

// One sample beat per timer tick goes in and one result beat comes out, one
// beat per clock cycle sustained while m_tready stays high. A beat is held
// in an input register, then the comparator and delay mode logic run
// combinationally into the output register, where its result is presented.
// While a result waits, the input register takes one more beat and the input
// then stalls until the result is taken. The delay limit is the product
// delay_value * base_time, registered behind the delay_value and base_time
// registers, so configuration should settle before the next sample.
// The tick counter is COUNT_WIDTH bits wide and saturates.
module sensor_switch_output_timer_unit #(
  parameter int COUNT_WIDTH = 22
) (
  input  logic                       clk,
  input  logic                       rst,
  // sample stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [15:0]                s_tdata,  // adc_value[11:0], short_fault[12], zero pad
  // result stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,  // out_pin[0], detect[1], compare_bit[2], pad
  // configuration write port
  input  logic                       cfg_we,
  input  logic [sswt_pkg::IDX_W-1:0] cfg_index,
  input  logic [sswt_pkg::CFG_W-1:0] cfg_data
);
  import sswt_pkg::*;

  sswt_cfg_t        cfg;
  sswt_res_t        res;
  logic             in_valid;
  logic [ADC_W-1:0] in_adc;
  logic             in_fault;
  logic             out_valid;
  sswt_res_t        out_res;
  logic             advance;
  logic             pin_now;

  // configuration registers
  sswt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // comparator and timer
  sswt_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .step        (advance),
    .adc_value   (in_adc),
    .short_fault (in_fault),
    .res         (res),
    .pin_now     (pin_now)
  );

  // flow control, the held beat moves on when the output slot is free
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_adc   <= s_tdata[ADC_W-1:0];
      in_fault <= s_tdata[ADC_W];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_res.compare_bit, out_res.detect, out_res.out_pin};

  // a processed beat always lands in the output register
  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("processed beat did not reach the output register");

  // direct mode without fault drives the pin from detect
  a_direct_follows: assert property (@(posedge clk) disable iff (rst)
    (advance && !in_fault && cfg.delay_mode == MODE_DIRECT) |=> (m_tdata[0] == m_tdata[1]))
    else $error("direct mode pin differs from detect");

  // fault holds the pin at its earlier level
  a_fault_freeze: assert property (@(posedge clk) disable iff (rst)
    (advance && in_fault) |=> (m_tdata[0] == $past(pin_now)))
    else $error("pin changed while fault was reported");

endmodule

// ===== hw/rtl/sswt_cfg.sv =====
// sswt_cfg: configuration registers and the registered delay limit
// depends on sswt_pkg
`timescale 1ns / 1ps

module sswt_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [sswt_pkg::IDX_W-1:0] cfg_index,
  input  logic [sswt_pkg::CFG_W-1:0] cfg_data,
  output sswt_pkg::sswt_cfg_t       cfg
);
  import sswt_pkg::*;

  logic [THR_W-1:0]   threshold;
  logic [HYST_W-1:0]  hysteresis;
  logic               polarity;
  logic [MODE_W-1:0]  delay_mode;
  logic [DVAL_W-1:0]  delay_value;
  logic [BASE_W-1:0]  base_time;
  logic [LIMIT_W-1:0] limit;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= RST_THRESHOLD;
      hysteresis  <= RST_HYSTERESIS;
      polarity    <= RST_POLARITY;
      delay_mode  <= RST_DELAY_MODE;
      delay_value <= RST_DELAY_VALUE;
      base_time   <= RST_BASE_TIME;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD:   threshold   <= cfg_data[THR_W-1:0];
        REG_HYSTERESIS:  hysteresis  <= cfg_data[HYST_W-1:0];
        REG_POLARITY:    polarity    <= cfg_data[0];
        REG_DELAY_MODE:  delay_mode  <= cfg_data[MODE_W-1:0];
        REG_DELAY_VALUE: delay_value <= cfg_data[DVAL_W-1:0];
        REG_BASE_TIME:   base_time   <= cfg_data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // delay limit in ticks, registered from the delay value and base time registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_W'(RST_DELAY_VALUE) * LIMIT_W'(RST_BASE_TIME);
    end else begin
      limit <= LIMIT_W'(delay_value) * LIMIT_W'(base_time);
    end
  end

  assign cfg.threshold  = threshold;
  assign cfg.hysteresis = hysteresis;
  assign cfg.polarity   = polarity;
  assign cfg.delay_mode = delay_mode;
  assign cfg.limit      = limit;

endmodule

// ===== hw/rtl/sswt_core.sv =====
// sswt_core: hysteresis comparator, delay mode logic and timer state
// depends on sswt_pkg
`timescale 1ns / 1ps

module sswt_core #(
  parameter int COUNT_WIDTH = 22
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sswt_pkg::sswt_cfg_t       cfg,
  input  logic                      step,
  input  logic [sswt_pkg::ADC_W-1:0] adc_value,
  input  logic                      short_fault,
  output sswt_pkg::sswt_res_t       res,
  output logic                      pin_now
);
  import sswt_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

  logic                   compare_state;
  logic [COUNT_WIDTH-1:0] tick_count;
  logic                   pin_level;
  logic                   shot_active;

  logic                   compare_state_next;
  logic [COUNT_WIDTH-1:0] tick_count_next;
  logic                   pin_level_next;
  logic                   shot_active_next;

  logic signed [THR_W+1:0] adc_s;
  logic signed [THR_W+1:0] clr_s;
  logic [CMP_W-1:0]        count_ext;
  logic [CMP_W-1:0]        limit_ext;
  logic                    det;
  logic                    over;
  logic                    under;
  logic                    clear;
  logic                    pin_mode;
  logic                    shot_mode;

  // comparator, clear level may drop below zero
  always_comb begin
    adc_s = signed'({2'b00, adc_value});
    clr_s = signed'({2'b00, cfg.threshold}) - signed'({6'b0, cfg.hysteresis});
    if (adc_value >= cfg.threshold) begin
      compare_state_next = 1'b1;
    end else if (adc_s <= clr_s) begin
      compare_state_next = 1'b0;
    end else begin
      compare_state_next = compare_state;
    end
    det = (compare_state_next == cfg.polarity);
  end

  // count against limit
  assign count_ext = CMP_W'(tick_count);
  assign limit_ext = CMP_W'(cfg.limit);
  assign over      = count_ext > limit_ext;
  assign under     = count_ext < limit_ext;

  // delay mode decision
  always_comb begin
    pin_mode  = pin_level;
    shot_mode = shot_active;
    clear     = 1'b0;
    unique case (cfg.delay_mode)
      MODE_DIRECT: begin
        pin_mode = det;
        clear    = 1'b1;
      end
      MODE_OFF_DELAY: begin
        if (det) begin
          pin_mode = 1'b1;
          clear    = 1'b1;
        end else if (over) begin
          pin_mode = 1'b0;
        end
      end
      MODE_ON_DELAY: begin
        if (det) begin
          if (over) pin_mode = 1'b1;
        end else begin
          pin_mode = 1'b0;
          clear    = 1'b1;
        end
      end
      MODE_ONE_SHOT: begin
        if (det || shot_active) begin
          pin_mode  = under;
          shot_mode = under;
        end else begin
          pin_mode = 1'b0;
          clear    = 1'b1;
        end
      end
    endcase
  end

  // fault freezes pin, counter and shot flag
  always_comb begin
    if (short_fault) begin
      pin_level_next   = pin_level;
      shot_active_next = shot_active;
      tick_count_next  = tick_count;
    end else begin
      pin_level_next   = pin_mode;
      shot_active_next = shot_mode;
      if (clear) begin
        tick_count_next = '0;
      end else if (tick_count != {COUNT_WIDTH{1'b1}}) begin
        tick_count_next = tick_count + 1'b1;
      end else begin
        tick_count_next = tick_count;
      end
    end
  end

  // state update once per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      compare_state <= 1'b0;
      tick_count    <= '0;
      pin_level     <= 1'b0;
      shot_active   <= 1'b0;
    end else if (step) begin
      compare_state <= compare_state_next;
      tick_count    <= tick_count_next;
      pin_level     <= pin_level_next;
      shot_active   <= shot_active_next;
    end
  end

  assign res.out_pin     = pin_level_next;
  assign res.detect      = det;
  assign res.compare_bit = compare_state_next;
  assign pin_now         = pin_level;

endmodule
